[rtl/strongest_signal_dedup_table_unit_assert.svh]
// Assertion macros for the strongest-signal dedup table unit.
// Used by the top level; no other dependencies.
`ifndef STRONGEST_SIGNAL_DEDUP_TABLE_UNIT_ASSERT_SVH
`define STRONGEST_SIGNAL_DEDUP_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define SSD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SSD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition");
`else
`define SSD_ASSERT(lbl, clk, rst_n, prop)
`define SSD_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

[rtl/ssdt_pkg.sv]
// Package for the strongest-signal dedup table: payload structs and constants.
// No dependencies.
`timescale 1ns / 1ps
package ssdt_pkg;
  localparam int unsigned NameWords = 4;

  typedef struct packed {
    logic        is_end;
    logic [7:0]  name_length;
    logic [63:0] name_word_0;
    logic [63:0] name_word_1;
    logic [63:0] name_word_2;
    logic [63:0] name_word_3;
    logic signed [7:0] strength;
    logic [7:0]  auth_kind;
  } in_item_t;

  typedef struct packed {
    logic        valid_res;
    logic        last;
    logic [4:0]  entries_total;
    logic [5:0]  out_length;
    logic [63:0] out_word_0;
    logic [63:0] out_word_1;
    logic [63:0] out_word_2;
    logic [63:0] out_word_3;
    logic signed [7:0] out_strength;
    logic        out_secured;
  } out_item_t;

  // Classified command passed from the front end to the table engine
  typedef struct packed {
    logic        is_end;
    logic [5:0]  len;
    logic [255:0] name;
    logic signed [7:0] strength;
    logic        secured;
  } cmd_t;
endpackage

[rtl/ssdt_front.sv]
// Front end: accepts sightings, drops hidden names, clips and masks names.
// Depends on ssdt_pkg; feeds a two-entry command queue.
`timescale 1ns / 1ps
module ssdt_front #(
  parameter int unsigned NAME_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  output logic                full_o,
  input  ssdt_pkg::in_item_t  in_data_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output ssdt_pkg::cmd_t      cmd_o
);
  localparam logic [7:0] MaxLen = 8'(NAME_BYTES);

  ssdt_pkg::cmd_t cmd_c;
  logic [7:0] len_c;
  logic [255:0] raw_c;
  logic keep_c;

  // Classify and mask the incoming transaction
  always_comb begin
    raw_c = {in_data_i.name_word_3, in_data_i.name_word_2,
             in_data_i.name_word_1, in_data_i.name_word_0};
    len_c = (in_data_i.name_length > MaxLen) ? MaxLen : in_data_i.name_length;
    cmd_c.is_end = in_data_i.is_end;
    cmd_c.len = len_c[5:0];
    for (int b = 0; b < 32; b++) begin
      cmd_c.name[b*8 +: 8] = (b < int'(len_c)) ? raw_c[b*8 +: 8] : 8'h00;
    end
    cmd_c.strength = in_data_i.strength;
    cmd_c.secured = (in_data_i.auth_kind != 8'h00);
    keep_c = in_data_i.is_end || (in_data_i.name_length != 8'h00);
  end

  // Two-entry queue
  ssdt_pkg::cmd_t q_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o = (cnt_q == 2'd2);
  assign do_push = push_i && !full_o && keep_c;
  assign do_pop = cmd_valid_o && cmd_ready_i;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o = q_q[rd_q];

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) q_q[wr_q] <= cmd_c;
  end
endmodule

[rtl/ssdt_engine.sv]
// Table engine: sequential match/insert scan and selection-sort emit.
// Depends on ssdt_pkg; one entry examined per cycle.
`timescale 1ns / 1ps
module ssdt_engine #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  ssdt_pkg::cmd_t     cmd_i,
  output logic               empty_o,
  input  logic               pop_i,
  output ssdt_pkg::out_item_t out_data_o
);
  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StFind = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;
  localparam logic [2:0] StWait = 3'd4;

  // Result for an empty table: only the last flag is set
  localparam ssdt_pkg::out_item_t EmptyRes = '{last: 1'b1, default: '0};

  logic [255:0] names_q [TABLE_ENTRIES];
  logic [5:0] lens_q [TABLE_ENTRIES];
  logic signed [7:0] str_q [TABLE_ENTRIES];
  logic sec_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] done_q;
  logic [CntW-1:0] count_q;
  logic [2:0] st_q;
  logic [CntW-1:0] idx_q, emitted_q;
  ssdt_pkg::cmd_t cur_q;
  logic [IdxW-1:0] best_q;
  logic have_q;
  logic out_v_q;
  ssdt_pkg::out_item_t out_q;

  logic [IdxW-1:0] ix;
  logic hit;
  logic better;
  logic load_c;
  assign ix = idx_q[IdxW-1:0];
  assign hit = (lens_q[ix] == cur_q.len) && (names_q[ix] == cur_q.name);
  // strictly stronger, so ties keep the lower (older) index
  assign better = !done_q[ix] && (!have_q || (str_q[ix] > str_q[best_q]));
  // load a new result into the output register
  assign load_c = ((st_q == StEmit) || (st_q == StWait)) && (!out_v_q || pop_i);

  assign cmd_ready_o = (st_q == StIdle);
  assign empty_o = !out_v_q;
  assign out_data_o = out_q;

  // Sequence scans and emission
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      count_q <= '0;
      idx_q <= '0;
      emitted_q <= '0;
      have_q <= 1'b0;
      done_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (load_c) out_v_q <= 1'b1;
      else if (pop_i) out_v_q <= 1'b0;
      unique case (st_q)
        StIdle: begin
          if (cmd_valid_i) begin
            idx_q <= '0;
            have_q <= 1'b0;
            done_q <= '0;
            emitted_q <= '0;
            if (cmd_i.is_end) st_q <= StFind;
            else st_q <= StScan;
          end
        end
        StScan: begin
          if (idx_q == count_q) begin
            if (count_q < CntW'(TABLE_ENTRIES)) count_q <= count_q + 1'b1;
            st_q <= StIdle;
          end else if (hit) begin
            st_q <= StIdle;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        StFind: begin
          if (count_q == '0) begin
            st_q <= StWait;
          end else if (idx_q == count_q) begin
            st_q <= StEmit;
          end else begin
            if (better) begin
              best_q <= ix;
              have_q <= 1'b1;
            end
            idx_q <= idx_q + 1'b1;
          end
        end
        StEmit: begin
          if (!out_v_q || pop_i) begin
            done_q[best_q] <= 1'b1;
            emitted_q <= emitted_q + 1'b1;
            have_q <= 1'b0;
            idx_q <= '0;
            if (emitted_q + 1'b1 == count_q) begin
              count_q <= '0;
              st_q <= StIdle;
            end else begin
              st_q <= StFind;
            end
          end
        end
        StWait: begin
          if (!out_v_q || pop_i) begin
            st_q <= StIdle;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Hold the command and write table and result payloads
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && cmd_valid_i) cur_q <= cmd_i;
    if (st_q == StScan) begin
      if (idx_q == count_q) begin
        if (count_q < CntW'(TABLE_ENTRIES)) begin
          names_q[ix] <= cur_q.name;
          lens_q[ix] <= cur_q.len;
          str_q[ix] <= cur_q.strength;
          sec_q[ix] <= cur_q.secured;
        end
      end else if (hit && (cur_q.strength > str_q[ix])) begin
        str_q[ix] <= cur_q.strength;
        sec_q[ix] <= cur_q.secured;
      end
    end
    if (st_q == StEmit && (!out_v_q || pop_i)) begin
      out_q.valid_res <= 1'b1;
      out_q.last <= (emitted_q + 1'b1 == count_q);
      out_q.entries_total <= 5'(count_q);
      out_q.out_length <= lens_q[best_q];
      out_q.out_word_0 <= names_q[best_q][63:0];
      out_q.out_word_1 <= names_q[best_q][127:64];
      out_q.out_word_2 <= names_q[best_q][191:128];
      out_q.out_word_3 <= names_q[best_q][255:192];
      out_q.out_strength <= str_q[best_q];
      out_q.out_secured <= sec_q[best_q];
    end
    if (st_q == StWait && (!out_v_q || pop_i)) begin
      out_q <= EmptyRes;
    end
  end
endmodule

[rtl/strongest_signal_dedup_table_unit.sv]
// Strongest-signal dedup table. Sighting: taken from the front queue in the
// idle state, then scanned against the stored entries, one stored entry per
// cycle, until a match or the end; a new sighting is taken only after that.
// End item: a find pass over the entries, then an emit of the strongest result,
// repeated per result; an empty table answers with a single empty result.
// Async active-low reset empties the table and the queue; memories are not cleared.
`timescale 1ns / 1ps
`include "strongest_signal_dedup_table_unit_assert.svh"
module strongest_signal_dedup_table_unit #(
  parameter int unsigned TABLE_ENTRIES = 16,
  parameter int unsigned NAME_BYTES = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  ssdt_pkg::in_item_t  in_data_i,
  output logic                empty,
  input  logic                pop,
  output ssdt_pkg::out_item_t out_data_o
);
  logic cmd_valid, cmd_ready;
  ssdt_pkg::cmd_t cmd;

  ssdt_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .in_data_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  ssdt_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .empty_o(empty), .pop_i(pop), .out_data_o
  );

  `SSD_ASSERT(a_empty_len_zero, clk_i, rst_ni, (!empty && !out_data_o.valid_res) |-> (out_data_o.last && out_data_o.out_length == 6'd0))
  `SSD_ASSERT(a_len_bound, clk_i, rst_ni, (!empty && out_data_o.valid_res) |-> (out_data_o.out_length != 6'd0 && out_data_o.out_length <= 6'd32))
  `SSD_ASSERT_NEVER(a_total_bound, clk_i, rst_ni, !empty && out_data_o.entries_total > 5'(TABLE_ENTRIES))
endmodule
